// ===== rtl/gzhp_pkg.sv =====
// Package with the shared types and constants of the gzip header parser.
`timescale 1ns / 1ps

package gzhp_pkg;

  // Field widths
  localparam int LEN_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 16;

  // Fixed header bytes and layout
  localparam logic [BYTE_W-1:0] MAGIC_ID1  = 8'h1F;
  localparam logic [BYTE_W-1:0] MAGIC_ID2  = 8'h8B;
  localparam logic [BYTE_W-1:0] CM_DEFLATE = 8'h08;
  localparam logic [LEN_W-1:0]  FIXED_LEN  = 32'd10;
  localparam logic [LEN_W-1:0]  MIN_BUF_LEN = 32'd18;
  localparam logic [LEN_W-1:0]  HCRC_LEN   = 32'd2;

  // Header byte positions within the fixed part
  localparam logic [LEN_W-1:0] POS_ID1   = 32'd0;
  localparam logic [LEN_W-1:0] POS_ID2   = 32'd1;
  localparam logic [LEN_W-1:0] POS_CM    = 32'd2;
  localparam logic [LEN_W-1:0] POS_FLG   = 32'd3;

  // Flag bit masks
  localparam logic [BYTE_W-1:0] FLG_FHCRC    = 8'h02;
  localparam logic [BYTE_W-1:0] FLG_FEXTRA   = 8'h04;
  localparam logic [BYTE_W-1:0] FLG_FNAME    = 8'h08;
  localparam logic [BYTE_W-1:0] FLG_FCOMMENT = 8'h10;

  // Name limit after reset
  localparam logic [LIMIT_W-1:0] NAME_LIMIT_RST = 16'd256;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One input item
  typedef struct packed {
    logic              first;
    logic [LEN_W-1:0]  buffer_len;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic             status;
    logic [LEN_W-1:0] payload_offset;
  } result_t;

endpackage

// ===== rtl/gzhp_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps

interface gzhp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          first;
  logic [gzhp_pkg::LEN_W-1:0]    buffer_len;
  logic [gzhp_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, first, buffer_len, data_byte, input ready);
  modport sink   (input valid, first, buffer_len, data_byte, output ready);
endinterface

interface gzhp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [gzhp_pkg::LEN_W-1:0]    payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink   (input valid, status, payload_offset, output ready);
endinterface

interface gzhp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gzhp_pkg::LIMIT_W-1:0]  name_limit;

  modport source (output valid, name_limit, input ready);
  modport sink   (input valid, name_limit, output ready);
endinterface

// ===== rtl/gzip_header_parser.sv =====
// Top level of the gzip header parser: channel registers, name limit and parse core.
//
//   channel  direction  payload                          transfer
//   in_ch    in         first, buffer_len, data_byte      one buffer byte
//   out_ch   out        status, payload_offset            at most one result per buffer
//   cfg_ch   in         name_limit                        name limit write
//
// Each byte is registered at the input and decided from that register, and each result is registered
// in turn; one byte is taken every cycle unless a held result backs up the input register.
// The per-byte state update in the parse core is the loop that sets this rate.
// Reset is synchronous and active low; it clears the parse and sets the name limit to 256.
// A held result stalls the input only once the input register is also full.
`timescale 1ns / 1ps

module gzip_header_parser (
  input  logic             clk,
  input  logic             rst_n,
  gzhp_in_if.sink          in_ch,
  gzhp_out_if.source       out_ch,
  gzhp_cfg_if.sink         cfg_ch
);
  import gzhp_pkg::*;

  logic [LIMIT_W-1:0] name_limit_r;
  logic               s1_valid_r;
  item_t              s1_item_r;
  logic               out_valid_r;
  result_t            out_res_r;
  logic               adv;
  logic               step_valid;
  logic               res_valid;
  result_t            res;

  // Name limit register; writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r <= NAME_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      name_limit_r <= cfg_ch.name_limit;
    end
  end

  // The input register moves on when the result register can take a result
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign step_valid   = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.first      <= in_ch.first;
      s1_item_r.buffer_len <= in_ch.buffer_len;
      s1_item_r.data_byte  <= in_ch.data_byte;
    end
  end

  // Parse state and decision
  gzhp_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .item       (s1_item_r),
    .name_limit (name_limit_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_valid && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_valid && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.payload_offset = out_res_r.payload_offset;

endmodule

// ===== rtl/gzhp_parse_core.sv =====
// Parse state and per-byte decision logic of the gzip header parser.
`timescale 1ns / 1ps

module gzhp_parse_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_valid,
  input  gzhp_pkg::item_t              item,
  input  logic [gzhp_pkg::LIMIT_W-1:0] name_limit,
  output logic                         res_valid,
  output gzhp_pkg::result_t            res
);
  import gzhp_pkg::*;

  // Parse phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_FIXED   = 9'b000000010,
    PH_XLO     = 9'b000000100,
    PH_XHI     = 9'b000001000,
    PH_XDATA   = 9'b000010000,
    PH_NAME    = 9'b000100000,
    PH_COMMENT = 9'b001000000,
    PH_CRC_LO  = 9'b010000000,
    PH_CRC_HI  = 9'b100000000
  } phase_t;

  // Optional field at which the walk resumes
  typedef enum logic [2:0] {
    ST_EXTRA   = 3'd0,
    ST_NAME    = 3'd1,
    ST_COMMENT = 3'd2,
    ST_HCRC    = 3'd3,
    ST_END     = 3'd4
  } stage_t;

  typedef struct packed {
    logic   done;
    logic   status;
    phase_t phase;
  } enter_t;

  // Picks the next optional field present, or the outcome when none is left or a field cannot be entered.
  function automatic enter_t enter_stage(input stage_t stage,
                                         input logic [BYTE_W-1:0] flags,
                                         input logic [LIMIT_W-1:0] limit,
                                         input logic [LEN_W-1:0] rem);
    enter_t e;
    e.done   = 1'b0;
    e.status = STATUS_OK;
    e.phase  = PH_IDLE;
    if (stage <= ST_EXTRA && (flags & FLG_FEXTRA) != '0) begin
      e.phase = PH_XLO;
    end else if (stage <= ST_NAME && (flags & FLG_FNAME) != '0) begin
      if (limit == '0) begin
        e.done   = 1'b1;
        e.status = STATUS_ERR;
      end else begin
        e.phase = PH_NAME;
      end
    end else if (stage <= ST_COMMENT && (flags & FLG_FCOMMENT) != '0) begin
      e.phase = PH_COMMENT;
    end else if (stage <= ST_HCRC && (flags & FLG_FHCRC) != '0) begin
      if (rem < HCRC_LEN) begin
        e.done   = 1'b1;
        e.status = STATUS_ERR;
      end else begin
        e.phase = PH_CRC_LO;
      end
    end else begin
      e.done   = 1'b1;
      e.status = (rem == '0) ? STATUS_ERR : STATUS_OK;
    end
    return e;
  endfunction

  // State registers; rem_r tracks the bytes left in the buffer
  phase_t              phase_r, phase_nxt;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [BYTE_W-1:0]   flags_r, flags_nxt;
  logic [LIMIT_W-1:0]  xrem_r, xrem_nxt;
  logic [BYTE_W-1:0]   xlo_r, xlo_nxt;
  logic [LIMIT_W-1:0]  ncnt_r, ncnt_nxt;

  // View of the state as this byte sees it; a first byte restarts the parse
  phase_t              cur_phase;
  logic [LEN_W-1:0]    cur_pos;
  logic [LEN_W-1:0]    cur_rem;
  logic [BYTE_W-1:0]   cur_flags;
  logic [LEN_W-1:0]    pos_inc;
  logic [LEN_W-1:0]    rem_dec;
  logic [LIMIT_W-1:0]  xlen;
  logic [LIMIT_W-1:0]  xrem_dec;
  logic [LIMIT_W-1:0]  ncnt_inc;
  logic                stage_go;
  stage_t              stage_sel;
  enter_t              ent;

  assign cur_phase = item.first ? PH_FIXED : phase_r;
  assign cur_pos   = item.first ? '0 : pos_r;
  assign cur_rem   = item.first ? item.buffer_len : rem_r;
  assign cur_flags = item.first ? '0 : flags_r;
  assign pos_inc   = cur_pos + LEN_W'(1);
  assign rem_dec   = cur_rem - LEN_W'(1);
  assign xlen      = {item.data_byte, xlo_r};
  assign xrem_dec  = xrem_r - LIMIT_W'(1);
  assign ncnt_inc  = ncnt_r + LIMIT_W'(1);

  // Per-byte decision
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    flags_nxt = flags_r;
    xrem_nxt  = xrem_r;
    xlo_nxt   = xlo_r;
    ncnt_nxt  = ncnt_r;
    res_valid = 1'b0;
    res       = '0;
    stage_go  = 1'b0;
    stage_sel = ST_EXTRA;
    ent       = '0;

    if (step_valid && (item.first || phase_r != PH_IDLE)) begin
      if (item.first && item.buffer_len < MIN_BUF_LEN) begin
        // Buffer shorter than the minimum buffer length is rejected at once
        res_valid  = 1'b1;
        res.status = STATUS_ERR;
        phase_nxt  = PH_IDLE;
      end else begin
        pos_nxt   = pos_inc;
        rem_nxt   = rem_dec;
        flags_nxt = cur_flags;
        phase_nxt = cur_phase;
        ncnt_nxt  = '0;

        unique case (cur_phase)
          PH_FIXED: begin
            if ((cur_pos == POS_ID1 && item.data_byte != MAGIC_ID1) ||
                (cur_pos == POS_ID2 && item.data_byte != MAGIC_ID2) ||
                (cur_pos == POS_CM && item.data_byte != CM_DEFLATE)) begin
              res_valid  = 1'b1;
              res.status = STATUS_ERR;
              phase_nxt  = PH_IDLE;
            end else begin
              if (cur_pos == POS_FLG) begin
                flags_nxt = item.data_byte;
              end
              if (pos_inc == FIXED_LEN) begin
                stage_go  = 1'b1;
                stage_sel = ST_EXTRA;
              end
            end
          end
          PH_XLO: begin
            xlo_nxt   = item.data_byte;
            phase_nxt = PH_XHI;
          end
          PH_XHI: begin
            if (LEN_W'(xlen) > rem_dec) begin
              res_valid  = 1'b1;
              res.status = STATUS_ERR;
              phase_nxt  = PH_IDLE;
            end else begin
              xrem_nxt = xlen;
              if (xlen == '0) begin
                stage_go  = 1'b1;
                stage_sel = ST_NAME;
              end else begin
                phase_nxt = PH_XDATA;
              end
            end
          end
          PH_XDATA: begin
            xrem_nxt = xrem_dec;
            if (xrem_dec == '0) begin
              stage_go  = 1'b1;
              stage_sel = ST_NAME;
            end
          end
          PH_NAME: begin
            ncnt_nxt = ncnt_inc;
            if (item.data_byte == '0) begin
              stage_go  = 1'b1;
              stage_sel = ST_COMMENT;
            end else if (ncnt_inc >= name_limit) begin
              res_valid  = 1'b1;
              res.status = STATUS_ERR;
              phase_nxt  = PH_IDLE;
            end
          end
          PH_COMMENT: begin
            if (item.data_byte == '0) begin
              stage_go  = 1'b1;
              stage_sel = ST_HCRC;
            end
          end
          PH_CRC_LO: begin
            phase_nxt = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            stage_go  = 1'b1;
            stage_sel = ST_END;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase

        // Move on to the next optional field or settle the outcome
        if (stage_go) begin
          ent = enter_stage(stage_sel, flags_nxt, name_limit, rem_dec);
          if (ent.done) begin
            res_valid          = 1'b1;
            res.status         = ent.status;
            res.payload_offset = (ent.status == STATUS_OK) ? pos_inc : '0;
            phase_nxt          = PH_IDLE;
          end else begin
            phase_nxt = ent.phase;
          end
        end

        // The buffer ran out in the middle of the header
        if (!res_valid && phase_nxt != PH_IDLE && rem_dec == '0) begin
          res_valid          = 1'b1;
          res.status         = STATUS_ERR;
          res.payload_offset = '0;
          phase_nxt          = PH_IDLE;
        end
      end
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      rem_r   <= '0;
      flags_r <= '0;
      xrem_r  <= '0;
      xlo_r   <= '0;
      ncnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      flags_r <= flags_nxt;
      xrem_r  <= xrem_nxt;
      xlo_r   <= xlo_nxt;
      ncnt_r  <= ncnt_nxt;
    end
  end

endmodule

// ===== test/tb_gzip_header_parser.sv =====
// Self-checking testbench for the gzip header parser with a byte-level predictor.
`timescale 1ns / 1ps

module tb_gzip_header_parser;
  import gzhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned BATCH_ITEMS = 135;

  // Parse phases and the optional field walk of the header.
  typedef enum logic [3:0] {
    P_IDLE, P_FIXED, P_XLO, P_XHI, P_XDATA, P_NAME, P_COMMENT, P_CRC_LO, P_CRC_HI
  } parse_phase_t;

  typedef enum int {
    FLD_EXTRA, FLD_NAME, FLD_COMMENT, FLD_HCRC, FLD_TAIL
  } field_stage_t;

  // Which side of the channels idles at random.
  typedef enum logic [1:0] {MODE_SINK_HEAVY, MODE_SOURCE_HEAVY, MODE_NO_IDLE} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  gzhp_in_if  in_if();
  gzhp_out_if out_if();
  gzhp_cfg_if cfg_if();

  gzip_header_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t       pending_bytes[$];
  result_t     expected_verdicts[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  idle_mode_t  idle_mode = MODE_SINK_HEAVY;
  int unsigned hold_reqs = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;

  // Predictor state, a private copy of the parser's registers.
  parse_phase_t      hp_phase = P_IDLE;
  logic [LEN_W-1:0]  hp_pos = '0;
  logic [LEN_W-1:0]  hp_total = '0;
  logic [BYTE_W-1:0] hp_flags = '0;
  logic [15:0]       hp_xleft = '0;
  logic [BYTE_W-1:0] hp_xlow = '0;
  logic [15:0]       hp_ncount = '0;
  logic              hp_done = 1'b1;
  logic [LIMIT_W-1:0] hp_limit = NAME_LIMIT_RST;

  // Record the verdict for the current buffer and return to idle.
  function automatic void issue_verdict(logic st, logic [LEN_W-1:0] offset);
    result_t r;
    r.status = st;
    r.payload_offset = offset;
    expected_verdicts.push_back(r);
    hp_done = 1'b1;
    hp_phase = P_IDLE;
  endfunction

  // Move on to the first present optional field at or after the given stage, or issue the verdict.
  function automatic void enter_next_field(field_stage_t stage);
    if (stage <= FLD_EXTRA && (hp_flags & FLG_FEXTRA) != 0) begin
      hp_phase = P_XLO;
      return;
    end
    if (stage <= FLD_NAME && (hp_flags & FLG_FNAME) != 0) begin
      if (hp_limit == 0) begin
        issue_verdict(STATUS_ERR, '0);
      end else begin
        hp_ncount = '0;
        hp_phase = P_NAME;
      end
      return;
    end
    if (stage <= FLD_COMMENT && (hp_flags & FLG_FCOMMENT) != 0) begin
      hp_phase = P_COMMENT;
      return;
    end
    if (stage <= FLD_HCRC && (hp_flags & FLG_FHCRC) != 0) begin
      if ({1'b0, hp_pos} + {1'b0, HCRC_LEN} > {1'b0, hp_total}) begin
        issue_verdict(STATUS_ERR, '0);
      end else begin
        hp_phase = P_CRC_LO;
      end
      return;
    end
    if (hp_pos >= hp_total) begin
      issue_verdict(STATUS_ERR, '0);
    end else begin
      issue_verdict(STATUS_OK, hp_pos);
    end
  endfunction

  // Advance the predicted parse by one accepted byte.
  function automatic void parse_header_byte(item_t it);
    logic [LEN_W-1:0]  at;
    logic [LEN_W-1:0]  xlen;
    logic [BYTE_W-1:0] b;
    b = it.data_byte;
    if (it.first) begin
      hp_pos = '0;
      hp_total = it.buffer_len;
      hp_flags = '0;
      hp_xleft = '0;
      hp_xlow = '0;
      hp_ncount = '0;
      hp_done = 1'b0;
      hp_phase = P_FIXED;
      if (hp_total < MIN_BUF_LEN) begin
        issue_verdict(STATUS_ERR, '0);
        return;
      end
    end else if (hp_done) begin
      return;
    end
    at = hp_pos;
    hp_pos = hp_pos + 1;
    case (hp_phase)
      P_FIXED: begin
        if ((at == POS_ID1 && b != MAGIC_ID1) || (at == POS_ID2 && b != MAGIC_ID2) ||
            (at == POS_CM && b != CM_DEFLATE)) begin
          issue_verdict(STATUS_ERR, '0);
          return;
        end
        if (at == POS_FLG) hp_flags = b;
        if (hp_pos == FIXED_LEN) enter_next_field(FLD_EXTRA);
      end
      P_XLO: begin
        hp_xlow = b;
        hp_phase = P_XHI;
      end
      P_XHI: begin
        xlen = {16'd0, b, hp_xlow};
        if (xlen > hp_total - hp_pos) begin
          issue_verdict(STATUS_ERR, '0);
          return;
        end
        hp_xleft = xlen[15:0];
        if (xlen == 0) enter_next_field(FLD_NAME);
        else hp_phase = P_XDATA;
      end
      P_XDATA: begin
        hp_xleft = hp_xleft - 16'd1;
        if (hp_xleft == 0) enter_next_field(FLD_NAME);
      end
      P_NAME: begin
        hp_ncount = hp_ncount + 16'd1;
        if (b == 0) begin
          enter_next_field(FLD_COMMENT);
        end else if (hp_ncount >= hp_limit) begin
          issue_verdict(STATUS_ERR, '0);
          return;
        end
      end
      P_COMMENT: begin
        if (b == 0) enter_next_field(FLD_HCRC);
      end
      P_CRC_LO: hp_phase = P_CRC_HI;
      P_CRC_HI: enter_next_field(FLD_TAIL);
      default: begin
        hp_done = 1'b1;
        hp_phase = P_IDLE;
        return;
      end
    endcase
    // A buffer that runs out before the header is settled is rejected.
    if (!hp_done && hp_pos >= hp_total) issue_verdict(STATUS_ERR, '0);
  endfunction

  function automatic int unsigned src_idle_pct();
    case (idle_mode)
      MODE_SINK_HEAVY:   return 15;
      MODE_SOURCE_HEAVY: return 59;
      default:           return 0;
    endcase
  endfunction

  function automatic int unsigned sink_idle_pct();
    case (idle_mode)
      MODE_SINK_HEAVY:   return 59;
      MODE_SOURCE_HEAVY: return 15;
      default:           return 0;
    endcase
  endfunction

  // Input driver: offers the next pending byte once the previous transfer is done.
  always @(posedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct()) begin
        nxt = pending_bytes.pop_front();
        in_if.first <= nxt.first;
        in_if.buffer_len <= nxt.buffer_len;
        in_if.data_byte <= nxt.data_byte;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct());
    end
  end

  // Monitor: checks each result transfer, then feeds config and byte transfers
  // to the predictor.
  always @(posedge clk) begin
    result_t want;
    item_t   seen;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: status %0d, payload_offset %0d",
                 out_if.status, out_if.payload_offset);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_if.status);
            fail_count++;
          end
          if (out_if.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, actual %0d",
                   want.payload_offset, out_if.payload_offset);
            fail_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) hp_limit = cfg_if.name_limit;
      if (in_if.valid && in_if.ready) begin
        seen.first = in_if.first;
        seen.buffer_len = in_if.buffer_len;
        seen.data_byte = in_if.data_byte;
        parse_header_byte(seen);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gzip_header_parser regression: fail");
      $finish;
    end
  end

  // Queue raw bytes; the lead byte carries the buffer length.
  task automatic queue_raw(input logic lead, input logic [LEN_W-1:0] blen,
                           input logic [BYTE_W-1:0] bytes[$]);
    item_t it;
    foreach (bytes[k]) begin
      it.first = lead && (k == 0);
      it.buffer_len = (k == 0) ? blen : LEN_W'($urandom);
      it.data_byte = bytes[k];
      pending_bytes.push_back(it);
    end
  endtask

  // Build one buffer: mostly well-formed headers with random optional fields,
  // the rest short, corrupted, truncated, of random length or with no payload byte.
  task automatic queue_buffer(output int unsigned counted);
    logic [BYTE_W-1:0] hdr[$];
    logic [BYTE_W-1:0] flags;
    logic [15:0]       xlen;
    logic [LEN_W-1:0]  blen;
    int unsigned       kind, hlen, npay, nsend, k;
    kind = $urandom_range(0, 99);
    flags = BYTE_W'($urandom);
    hdr = {MAGIC_ID1, MAGIC_ID2, CM_DEFLATE, flags};
    repeat (6) hdr.push_back(BYTE_W'($urandom));
    if ((flags & FLG_FEXTRA) != 0) begin
      xlen = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      hdr.push_back(xlen[7:0]);
      hdr.push_back(xlen[15:8]);
      repeat ((xlen > 8) ? 8 : xlen) hdr.push_back(BYTE_W'($urandom));
    end
    if ((flags & FLG_FNAME) != 0) begin
      repeat ($urandom_range(0, 12)) hdr.push_back(BYTE_W'($urandom_range(1, 255)));
      if ($urandom_range(0, 7) != 0) hdr.push_back(8'h00);
    end
    if ((flags & FLG_FCOMMENT) != 0) begin
      repeat ($urandom_range(0, 5)) hdr.push_back(BYTE_W'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end
    if ((flags & FLG_FHCRC) != 0) begin
      repeat (2) hdr.push_back(BYTE_W'($urandom));
    end
    hlen = hdr.size();
    npay = $urandom_range(0, 3);
    if (hlen + npay < MIN_BUF_LEN) npay = MIN_BUF_LEN - hlen + $urandom_range(0, 2);
    repeat (npay) hdr.push_back(BYTE_W'($urandom));
    nsend = hdr.size();
    if (kind < 8) begin
      blen = $urandom_range(0, MIN_BUF_LEN - 1);
      nsend = $urandom_range(1, 3);
    end else if (kind < 14) begin
      k = $urandom_range(0, 2);
      hdr[k] = hdr[k] ^ BYTE_W'($urandom_range(1, 255));
      blen = hdr.size();
    end else if (kind < 26) begin
      blen = $urandom_range(MIN_BUF_LEN, hdr.size());
    end else if (kind < 34) begin
      blen = LEN_W'($urandom);
    end else if (kind < 44) begin
      // Header ending right at the buffer end leaves no payload byte.
      blen = hlen;
    end else begin
      blen = hdr.size();
    end
    // Now and then the next buffer starts before this one is settled.
    if ($urandom_range(0, 15) == 0) nsend = $urandom_range(1, nsend);
    while (hdr.size() > nsend) void'(hdr.pop_back());
    queue_raw(1'b1, blen, hdr);
    counted = nsend;
    // Stray bytes between buffers.
    if ($urandom_range(0, 5) == 0) begin
      hdr = {};
      repeat ($urandom_range(1, 2)) hdr.push_back(BYTE_W'($urandom));
      queue_raw(1'b0, '0, hdr);
      counted += hdr.size();
    end
  endtask

  task automatic queue_batch(input int unsigned items);
    int unsigned total, got;
    total = 0;
    while (total < items) begin
      queue_buffer(got);
      total += got;
    end
  endtask

  // Wait until every byte is taken and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_if.valid || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_name_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.name_limit <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    logic [BYTE_W-1:0] dir[$];
    in_if.valid = 1'b0;
    in_if.first = 1'b0;
    in_if.buffer_len = '0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.name_limit = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short lengths, each bad fixed byte, a stray byte, a dropped
    // parse and a maximum-length buffer with only ignored flag bits set.
    dir = {MAGIC_ID1};
    queue_raw(1'b1, '0, dir);
    queue_raw(1'b1, MIN_BUF_LEN - 1, dir);
    dir = {8'h00};
    queue_raw(1'b1, MIN_BUF_LEN, dir);
    dir = {MAGIC_ID1, 8'h8A};
    queue_raw(1'b1, MIN_BUF_LEN, dir);
    dir = {MAGIC_ID1, MAGIC_ID2, 8'h07};
    queue_raw(1'b1, MIN_BUF_LEN, dir);
    dir = {8'hFF};
    queue_raw(1'b0, '1, dir);
    dir = {MAGIC_ID1, MAGIC_ID2, CM_DEFLATE, 8'h00};
    queue_raw(1'b1, '1, dir);
    dir = {MAGIC_ID1, MAGIC_ID2, CM_DEFLATE, 8'hE1,
           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    queue_raw(1'b1, '1, dir);
    wait_drained();

    // Random phases over several name limits, 1 and 65535 included.
    write_name_limit(16'd1);
    queue_batch(BATCH_ITEMS);
    wait_drained();
    write_name_limit(16'hFFFF);
    queue_batch(BATCH_ITEMS);
    wait_drained();

    idle_mode <= MODE_SOURCE_HEAVY;
    write_name_limit(LIMIT_W'($urandom_range(2, 12)));
    // Long receiver hold-off while bytes keep coming, so the input backs up.
    hold_reqs <= hold_reqs + 1;
    queue_batch(BATCH_ITEMS);
    wait_drained();
    write_name_limit(LIMIT_W'($urandom_range(1, 65535)));
    queue_batch(BATCH_ITEMS);
    wait_drained();

    idle_mode <= MODE_NO_IDLE;
    write_name_limit(16'd3);
    queue_batch(BATCH_ITEMS);
    wait_drained();
    write_name_limit(NAME_LIMIT_RST);
    queue_batch(BATCH_ITEMS);
    wait_drained();

    if (expected_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", expected_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("gzip_header_parser regression: pass");
    end else begin
      $display("gzip_header_parser regression: fail");
    end
    $finish;
  end

endmodule
